// ===== hw/rtl/dest_pkg.sv =====
`default_nettype none

package dest_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_W        = 16;
  localparam int CMD_W       = 2;
  localparam int ECNT_W      = 5;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            active;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hw/rtl/diagnostic_event_status_table_unit.sv =====
`default_nettype none

// Channel  Direction  tdata                                   tuser
// in_      slave      [15:0] evt_id                           [1:0] command
// out_     master     [0] found, [1] active,                  none
//                     [2] table_full_reject, [7:3] entry_count
//
// An input beat is taken only while the unit is idle; the table RAM is then read one entry a
// cycle until the identifier matches or every stored entry has been read, and the result is
// then registered. The unit returns to idle as the result is registered, so the next input
// beat can be taken while that result still waits on the output.
// A stalled output holds the next command in its final step until the register frees.
// Synchronous active-low reset empties the table; the RAM itself is not cleared.

module diagnostic_event_status_table_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [15:0]                in_tdata,   // [15:0] evt_id
  input  wire logic [dest_pkg::CMD_W-1:0] in_tuser,   // [1:0] command
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [7:0]                 out_tdata   // [0] found, [1] active,
                                                      // [2] table_full_reject, [7:3] entry_count
);

  import dest_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] where_r, where_nxt;
  logic             act_r, act_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wentry;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic             full;
  logic             rej;
  logic             res_act;

  assign rd_entry   = entry_t'(ram_rdata);
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign full       = (cnt_r >= CNT_W'(TABLE_DEPTH));

  dest_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    where_nxt     = where_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = where_r;
    ram_wentry    = '{id: id_r, active: 1'b1};
    ram_raddr     = scan_idx_r[IDX_W-1:0];
    rej           = 1'b0;
    res_act       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_tuser;
          id_nxt       = in_tdata;
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          hit_nxt      = 1'b0;
          act_nxt      = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // The entry read last cycle is compared while the next one is fetched.
        if (pend_r && (rd_entry.id == id_r)) begin
          hit_nxt   = 1'b1;
          where_nxt = pend_idx_r;
          act_nxt   = rd_entry.active;
          pend_nxt  = 1'b0;
          state_nxt = ST_DECIDE;
        end else if (scan_idx_r == cnt_r) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DECIDE;
        end else begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
      end
      ST_DECIDE: begin
        if (!out_valid_r || out_tready) begin
          priority if (cmd_r == CMD_REPORT) begin
            if (full) begin
              rej     = 1'b1;
              res_act = hit_r & act_r;
            end else if (hit_r) begin
              ram_we  = 1'b1;
              res_act = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[IDX_W-1:0];
              cnt_nxt   = cnt_r + CNT_W'(1);
              res_act   = 1'b1;
            end
          end else if (cmd_r == CMD_CLEAR) begin
            ram_we     = hit_r;
            ram_wentry = '{id: id_r, active: 1'b0};
            res_act    = 1'b0;
          end else begin
            // Check, and the unused fourth code, only read.
            res_act = hit_r & act_r;
          end
          out_data_nxt  = {ECNT_W'(cnt_nxt), rej, res_act, hit_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    where_r    <= where_nxt;
    act_r      <= act_nxt;
    out_data_r <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(!rst_n) |-> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2]) |-> (out_data_r[7:3] == ECNT_W'(TABLE_DEPTH)))
    else $error("reject reported on a table that is not full");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN) && (CNT_W'(pend_idx_r) < cnt_r))
    else $error("table read outside the scan or beyond stored entries");

  a_write_decide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_DECIDE) && (state_nxt == ST_IDLE))
    else $error("table written outside the final step");

endmodule

`default_nettype wire

// ===== hw/rtl/dest_ram.sv =====
`default_nettype none

module dest_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
